FILE: src/fql_pkg.sv
// ----------------------------------------------------------------------------
// fql_pkg
// Shared types, register codes, reset values and the blink-counter helper for the fault
// qualifier and LED driver.
// ----------------------------------------------------------------------------
package fql_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_POWER_COUNT_MAX         = 3'd0,
        CFG_POWER_FAULT_THRESHOLD   = 3'd1,
        CFG_FAN_CONFIRM_TICKS       = 3'd2,
        CFG_FAN_MIN_BUS_VOLTAGE     = 3'd3,
        CFG_READY_CONFIRM_TICKS     = 3'd4,
        CFG_NOT_READY_CONFIRM_TICKS = 3'd5,
        CFG_BLINK_HALF_PERIOD       = 3'd6,
        CFG_RESET_REASON_LIMIT      = 3'd7
    } t_cfg_idx;

    localparam logic [3:0]         RST_POWER_COUNT_MAX         = 4'd10;
    localparam logic [3:0]         RST_POWER_FAULT_THRESHOLD   = 4'd3;
    localparam logic [11:0]        RST_FAN_CONFIRM_TICKS       = 12'd3000;
    localparam logic signed [15:0] RST_FAN_MIN_BUS_VOLTAGE     = 16'sd2528;
    localparam logic [11:0]        RST_READY_CONFIRM_TICKS     = 12'd2000;
    localparam logic [3:0]         RST_NOT_READY_CONFIRM_TICKS = 4'd5;
    localparam logic [11:0]        RST_BLINK_HALF_PERIOD       = 12'd1000;
    localparam logic [3:0]         RST_RESET_REASON_LIMIT      = 4'd5;

    localparam logic [1:0] RECT_MINOR  = 2'd1;
    localparam logic [1:0] RECT_SEVERE = 2'd2;

    typedef struct packed {
        logic              tick_1ms;
        logic              power_ok_raw;
        logic              fan_fault_raw;
        logic signed [15:0] bus_voltage;
        logic [3:0]        off_reason;
        logic              ready_raw;
        logic              inverter_on;
        logic              output_relay_on;
        logic              severe_fault_any;
        logic              minor_fault_any;
        logic [1:0]        rectifier_fault;
    } t_in_item;

    typedef struct packed {
        logic aux_supply_fault;
        logic pwm_disable;
        logic reset_command;
        logic fan_fault;
        logic module_ready_ok;
        logic manual_recover_off;
        logic red_led_n;
        logic green_led_n;
    } t_out_item;

    typedef struct packed {
        logic [3:0]         power_count_max;
        logic [3:0]         power_fault_threshold;
        logic [11:0]        fan_confirm_ticks;
        logic signed [15:0] fan_min_bus_voltage;
        logic [11:0]        ready_confirm_ticks;
        logic [3:0]         not_ready_confirm_ticks;
        logic [11:0]        blink_half_period;
        logic [3:0]         reset_reason_limit;
    } t_cfg;

    // qualifier results for the current transaction
    typedef struct packed {
        logic aux_fault;
        logic reset_cmd;
        logic fan_fault;
        logic ready_ok;
        logic manual_off;
    } t_qual;

    typedef struct packed {
        logic [11:0] count;
        logic        toggle;
    } t_blink;

    function automatic t_blink blink_step(input logic [11:0] count,
                                          input logic [11:0] half);
        logic [12:0] c;
        t_blink      r;
        c = {1'b0, count} + 13'd1;
        if (c >= {1'b0, half}) begin
            r.count  = 12'd0;
            r.toggle = 1'b1;
        end else begin
            r.count  = c[11:0];
            r.toggle = 1'b0;
        end
        return r;
    endfunction

endpackage

FILE: src/fql_cfg_regs.sv
// ----------------------------------------------------------------------------
// fql_cfg_regs
// Configuration register file, write only, loaded with defaults on reset.
// ----------------------------------------------------------------------------
module fql_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fql_pkg::CFG_IDX_W-1:0]    i_cfg_addr,
    input  logic [fql_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output fql_pkg::t_cfg                    o_cfg
);

    fql_pkg::t_cfg r_cfg;
    fql_pkg::t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (fql_pkg::t_cfg_idx'(i_cfg_addr))
                fql_pkg::CFG_POWER_COUNT_MAX:
                    n_cfg.power_count_max = i_cfg_wdata[3:0];
                fql_pkg::CFG_POWER_FAULT_THRESHOLD:
                    n_cfg.power_fault_threshold = i_cfg_wdata[3:0];
                fql_pkg::CFG_FAN_CONFIRM_TICKS:
                    n_cfg.fan_confirm_ticks = i_cfg_wdata[11:0];
                fql_pkg::CFG_FAN_MIN_BUS_VOLTAGE:
                    n_cfg.fan_min_bus_voltage = $signed(i_cfg_wdata[15:0]);
                fql_pkg::CFG_READY_CONFIRM_TICKS:
                    n_cfg.ready_confirm_ticks = i_cfg_wdata[11:0];
                fql_pkg::CFG_NOT_READY_CONFIRM_TICKS:
                    n_cfg.not_ready_confirm_ticks = i_cfg_wdata[3:0];
                fql_pkg::CFG_BLINK_HALF_PERIOD:
                    n_cfg.blink_half_period = i_cfg_wdata[11:0];
                fql_pkg::CFG_RESET_REASON_LIMIT:
                    n_cfg.reset_reason_limit = i_cfg_wdata[3:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.power_count_max         <= fql_pkg::RST_POWER_COUNT_MAX;
            r_cfg.power_fault_threshold   <= fql_pkg::RST_POWER_FAULT_THRESHOLD;
            r_cfg.fan_confirm_ticks       <= fql_pkg::RST_FAN_CONFIRM_TICKS;
            r_cfg.fan_min_bus_voltage     <= fql_pkg::RST_FAN_MIN_BUS_VOLTAGE;
            r_cfg.ready_confirm_ticks     <= fql_pkg::RST_READY_CONFIRM_TICKS;
            r_cfg.not_ready_confirm_ticks <= fql_pkg::RST_NOT_READY_CONFIRM_TICKS;
            r_cfg.blink_half_period       <= fql_pkg::RST_BLINK_HALF_PERIOD;
            r_cfg.reset_reason_limit      <= fql_pkg::RST_RESET_REASON_LIMIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/fql_qual.sv
// ----------------------------------------------------------------------------
// fql_qual
// Supply, fan and module-ready qualifiers. State advances once per
// transaction when i_en is high; o_qual carries this transaction's flags.
// ----------------------------------------------------------------------------
module fql_qual (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  fql_pkg::t_in_item i_item,
    input  fql_pkg::t_cfg     i_cfg,
    output fql_pkg::t_qual    o_qual
);

    logic [3:0]  r_pwr_cnt,  n_pwr_cnt;
    logic        r_pwr_prev;
    logic [11:0] r_fan_cnt,  n_fan_cnt;
    logic        r_fan_flag, n_fan_flag;
    logic [11:0] r_rdy_cnt,  n_rdy_cnt;
    logic [3:0]  r_nrdy_cnt, n_nrdy_cnt;
    logic        r_rdy_flag, n_rdy_flag;

    logic        aux_fault;
    logic [12:0] fan_inc;
    logic [12:0] rdy_inc;
    logic [4:0]  nrdy_inc;

    // supply counter: saturating up/down
    always_comb begin
        n_pwr_cnt = r_pwr_cnt;
        if (!i_item.power_ok_raw && (r_pwr_cnt < i_cfg.power_count_max)) begin
            n_pwr_cnt = r_pwr_cnt + 4'd1;
        end else if (i_item.power_ok_raw && (r_pwr_cnt != 4'd0)) begin
            n_pwr_cnt = r_pwr_cnt - 4'd1;
        end
        aux_fault = (n_pwr_cnt >= i_cfg.power_fault_threshold);
    end

    // fan run-length qualifier, gated by bus voltage
    always_comb begin
        fan_inc    = {1'b0, r_fan_cnt} + 13'd1;
        n_fan_cnt  = r_fan_cnt;
        n_fan_flag = r_fan_flag;
        if (i_item.tick_1ms) begin
            if (i_item.fan_fault_raw
                && ($signed(i_item.bus_voltage) >= $signed(i_cfg.fan_min_bus_voltage))) begin
                if (fan_inc >= {1'b0, i_cfg.fan_confirm_ticks}) begin
                    n_fan_cnt  = i_cfg.fan_confirm_ticks;
                    n_fan_flag = 1'b1;
                end else begin
                    n_fan_cnt = fan_inc[11:0];
                end
            end else begin
                n_fan_cnt  = 12'd0;
                n_fan_flag = 1'b0;
            end
        end
    end

    // module ready: separate confirm and release counts
    always_comb begin
        rdy_inc    = {1'b0, r_rdy_cnt} + 13'd1;
        nrdy_inc   = {1'b0, r_nrdy_cnt} + 5'd1;
        n_rdy_cnt  = r_rdy_cnt;
        n_nrdy_cnt = r_nrdy_cnt;
        n_rdy_flag = r_rdy_flag;
        if (i_item.tick_1ms) begin
            if (i_item.ready_raw) begin
                n_nrdy_cnt = 4'd0;
                if (rdy_inc >= {1'b0, i_cfg.ready_confirm_ticks}) begin
                    n_rdy_cnt  = i_cfg.ready_confirm_ticks;
                    n_rdy_flag = 1'b1;
                end else begin
                    n_rdy_cnt = rdy_inc[11:0];
                end
            end else begin
                n_rdy_cnt = 12'd0;
                if (nrdy_inc >= {1'b0, i_cfg.not_ready_confirm_ticks}) begin
                    n_nrdy_cnt = i_cfg.not_ready_confirm_ticks;
                    n_rdy_flag = 1'b0;
                end else begin
                    n_nrdy_cnt = nrdy_inc[3:0];
                end
            end
        end
    end

    always_comb begin
        o_qual.aux_fault  = aux_fault;
        // clear request only on the pass where the fault drops out
        o_qual.reset_cmd  = !aux_fault && r_pwr_prev
                            && (i_item.off_reason < i_cfg.reset_reason_limit);
        o_qual.fan_fault  = n_fan_flag;
        o_qual.ready_ok   = n_rdy_flag;
        o_qual.manual_off = aux_fault || (!n_rdy_flag && i_item.inverter_on);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwr_cnt  <= 4'd0;
            r_pwr_prev <= 1'b0;
            r_fan_cnt  <= 12'd0;
            r_fan_flag <= 1'b0;
            r_rdy_cnt  <= 12'd0;
            r_nrdy_cnt <= 4'd0;
            r_rdy_flag <= 1'b0;
        end else if (i_en) begin
            r_pwr_cnt  <= n_pwr_cnt;
            r_pwr_prev <= aux_fault;
            r_fan_cnt  <= n_fan_cnt;
            r_fan_flag <= n_fan_flag;
            r_rdy_cnt  <= n_rdy_cnt;
            r_nrdy_cnt <= n_nrdy_cnt;
            r_rdy_flag <= n_rdy_flag;
        end
    end

endmodule

FILE: src/fql_led.sv
// ----------------------------------------------------------------------------
// fql_led
// Red and green LED drivers with blink counters. Blink counters hold their
// value outside blink mode.
// ----------------------------------------------------------------------------
module fql_led (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  fql_pkg::t_in_item i_item,
    input  fql_pkg::t_qual    i_qual,
    input  logic [11:0]       i_half_period,
    output logic              o_red_n,
    output logic              o_green_n
);

    logic [11:0]     r_red_cnt,   n_red_cnt;
    logic            r_red_lvl,   n_red_lvl;
    logic [11:0]     r_green_cnt, n_green_cnt;
    logic            r_green_lvl, n_green_lvl;
    logic            severe;
    logic            minor;
    fql_pkg::t_blink red_blk;
    fql_pkg::t_blink green_blk;

    assign red_blk   = fql_pkg::blink_step(r_red_cnt, i_half_period);
    assign green_blk = fql_pkg::blink_step(r_green_cnt, i_half_period);

    always_comb begin
        severe = i_item.severe_fault_any || (i_item.rectifier_fault == fql_pkg::RECT_SEVERE)
                 || !i_qual.ready_ok;
        minor  = i_item.minor_fault_any || (i_item.rectifier_fault == fql_pkg::RECT_MINOR)
                 || i_qual.fan_fault;
        n_red_cnt = r_red_cnt;
        priority if (severe) begin
            n_red_lvl = 1'b0;
        end else if (minor) begin
            n_red_cnt = red_blk.count;
            n_red_lvl = r_red_lvl ^ red_blk.toggle;
        end else begin
            n_red_lvl = 1'b1;
        end
    end

    always_comb begin
        n_green_cnt = r_green_cnt;
        priority if (i_item.output_relay_on) begin
            n_green_lvl = 1'b0;
        end else if (i_item.inverter_on) begin
            n_green_cnt = green_blk.count;
            n_green_lvl = r_green_lvl ^ green_blk.toggle;
        end else begin
            n_green_lvl = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_cnt   <= 12'd0;
            r_red_lvl   <= 1'b1;
            r_green_cnt <= 12'd0;
            r_green_lvl <= 1'b1;
        end else if (i_en) begin
            r_red_cnt   <= n_red_cnt;
            r_red_lvl   <= n_red_lvl;
            r_green_cnt <= n_green_cnt;
            r_green_lvl <= n_green_lvl;
        end
    end

    assign o_red_n   = n_red_lvl;
    assign o_green_n = n_green_lvl;

endmodule

FILE: src/fault_qualifier_led_driver_unit.sv
// ----------------------------------------------------------------------------
// fault_qualifier_led_driver_unit
// Power-module supervisor pass: supply, fan and ready qualification and
// LED drive, one result transaction per input transaction.
// ----------------------------------------------------------------------------
// Path: input register, then qualifier/LED logic into the result register.
// Throughput: one transaction per cycle while the output is not stalled;
//   the input register and result register let a new transaction in while
//   a result waits to be taken.
// Reset: synchronous, active low; registers load defaults, counters clear,
//   both LEDs dark, pipeline empty.
module fault_qualifier_led_driver_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  fql_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output fql_pkg::t_out_item             o_out_data,
    input  logic                           i_cfg_we,
    input  logic [fql_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [fql_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    fql_pkg::t_in_item  r_in;
    logic               r_in_vld;
    fql_pkg::t_out_item r_out, n_out;
    logic               r_out_vld;
    logic               advance;
    fql_pkg::t_cfg      cfg;
    fql_pkg::t_qual     qual;
    logic               red_n;
    logic               green_n;

    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;

    fql_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    fql_qual u_qual (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_qual  (qual)
    );

    fql_led u_led (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (advance),
        .i_item        (r_in),
        .i_qual        (qual),
        .i_half_period (cfg.blink_half_period),
        .o_red_n       (red_n),
        .o_green_n     (green_n)
    );

    always_comb begin
        n_out.aux_supply_fault   = qual.aux_fault;
        n_out.pwm_disable        = qual.aux_fault;
        n_out.reset_command      = qual.reset_cmd;
        n_out.fan_fault          = qual.fan_fault;
        n_out.module_ready_ok    = qual.ready_ok;
        n_out.manual_recover_off = qual.manual_off;
        n_out.red_led_n          = red_n;
        n_out.green_led_n        = green_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // a transaction moved into the result register must show up as valid
    a_advance_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(advance) |-> o_out_valid)
        else $error("result lost after advance");

    // clear request never together with an active supply fault
    a_reset_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.reset_command && o_out_data.aux_supply_fault))
        else $error("reset command during supply fault");

    // supply fault always requests a manual recoverable shutdown
    a_manual_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.aux_supply_fault |-> o_out_data.manual_recover_off)
        else $error("supply fault without shutdown request");

    // module not ready is a severe fault: red LED lit steadily
    a_red_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.module_ready_ok |-> !o_out_data.red_led_n)
        else $error("red LED dark while module not ready");

endmodule
